// File: src/salted_handle_slot_table_core_defines.svh
// Assertion macros for the slot table checker.
`ifndef SALTED_HANDLE_SLOT_TABLE_CORE_DEFINES_SVH
`define SALTED_HANDLE_SLOT_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define SHST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SHST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/shst_pkg.sv
// Shared types and constants for the salted handle slot table.
package shst_pkg;

    localparam int CAPACITY_DEF = 1024;

    localparam int OP_W       = 3;
    localparam int ID_W       = 16;
    localparam int SIDX_W     = 16;
    localparam int RES_IDX_W  = 10;
    localparam int TSIZE_W    = 11;
    localparam int CMP_W      = 17;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam logic [ID_W-1:0]    ID_WRAP      = 16'h8000;
    localparam logic [ID_W-1:0]    KEY_NONE     = 16'hFFFF;
    localparam logic [SIDX_W-1:0]  INDEX_NONE   = 16'hFFFF;
    localparam logic [TSIZE_W-1:0] TSIZE_RST    = 11'd1024;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 3'd0,
        OP_GET   = 3'd1,
        OP_FIND  = 3'd2,
        OP_CLEAR = 3'd3,
        OP_ITER  = 3'd4
    } op_t;

    localparam logic [1:0] REG_TABLE_SIZE = 2'd0;
    localparam logic [1:0] REG_ZERO_ID    = 2'd1;
    localparam logic [1:0] REG_NAME_SEED  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_CHECK = 4'b0100,
        ST_RESP  = 4'b1000
    } state_t;

    typedef struct packed {
        logic [TSIZE_W-1:0] table_size;
        logic               zero_id_invalid;
        logic [ID_W-1:0]    name_seed;
    } cfg_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

// File: src/shst_req_if.sv
// Request and response channel interfaces.
interface shst_req_if import shst_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [SIDX_W-1:0] slot_index;
    logic [ID_W-1:0]   ident;

    modport source (output valid, op, slot_index, ident, input ready);
    modport sink   (input valid, op, slot_index, ident, output ready);
endinterface

interface shst_rsp_if import shst_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 ok;
    logic [RES_IDX_W-1:0] result_index;
    logic [ID_W-1:0]      result_id;

    modport source (output valid, ok, result_index, result_id, input ready);
    modport sink   (input valid, ok, result_index, result_id, output ready);
endinterface

// File: src/shst_mem.sv
// Slot identifier memory, one write port and one registered read port.
module shst_mem import shst_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                        clk,
    input  mem_ctl_t                    ctl,
    input  logic [$clog2(CAPACITY)-1:0] waddr,
    input  logic [ID_W-1:0]             wdata,
    input  logic [$clog2(CAPACITY)-1:0] raddr,
    output logic [ID_W-1:0]             rdata
);
    logic [ID_W-1:0] slot_mem [CAPACITY];
    logic [ID_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            slot_mem[waddr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= slot_mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// File: src/shst_ctrl.sv
// Operation sequencer with the shared slot compare unit and result register.
module shst_ctrl import shst_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    shst_req_if.sink                    req,
    shst_rsp_if.source                  rsp,
    input  cfg_t                        cfg,
    output mem_ctl_t                    mem_ctl,
    output logic [$clog2(CAPACITY)-1:0] mem_waddr,
    output logic [ID_W-1:0]             mem_wdata,
    output logic [$clog2(CAPACITY)-1:0] mem_raddr,
    input  logic [ID_W-1:0]             mem_rdata
);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    state_t               state_reg, state_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [SIDX_W-1:0]    sidx_reg, sidx_next;
    logic [ID_W-1:0]      key_reg, key_next;
    logic [CNT_W-1:0]     scan_reg, scan_next;
    logic [CNT_W-1:0]     used_reg, used_next;
    logic                 full_reg, full_next;
    logic [ID_W-1:0]      nid_reg, nid_next;
    logic                 res_ok_reg, res_ok_next;
    logic [RES_IDX_W-1:0] res_idx_reg, res_idx_next;
    logic [ID_W-1:0]      res_id_reg, res_id_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_ok_reg, out_ok_next;
    logic [RES_IDX_W-1:0] out_idx_reg, out_idx_next;
    logic [ID_W-1:0]      out_id_reg, out_id_next;

    logic [CMP_W-1:0] eff_size;
    logic [CMP_W-1:0] used_ext;
    logic [CMP_W-1:0] sidx_ext;
    logic [CNT_W-1:0] scan_inc;
    logic [ID_W-1:0]  nid_inc;
    logic [ID_W-1:0]  word;
    logic [ID_W-1:0]  cmp_b;
    logic             word_eq;
    logic             hit;

    assign eff_size = (CMP_W'(cfg.table_size) > CMP_W'(CAPACITY)) ?
                      CMP_W'(CAPACITY) : CMP_W'(cfg.table_size);
    assign used_ext = CMP_W'(used_reg);
    assign sidx_ext = CMP_W'(req.slot_index);
    assign scan_inc = scan_reg + 1'b1;
    assign nid_inc  = nid_reg + 1'b1;

    // slots at or past the fill count are empty
    assign word    = (CMP_W'(scan_reg) < used_ext) ? mem_rdata : '0;
    assign cmp_b   = (op_reg == OP_ITER) ? '0 : key_reg;
    assign word_eq = (word == cmp_b);
    assign hit     = (op_reg == OP_FIND) ? word_eq : !word_eq;

    assign mem_waddr = used_reg[IDX_W-1:0];
    assign mem_wdata = nid_reg;
    assign mem_raddr = scan_reg[IDX_W-1:0];

    assign req.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.ok           = out_ok_reg;
    assign rsp.result_index = out_idx_reg;
    assign rsp.result_id    = out_id_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        sidx_next      = sidx_reg;
        key_next       = key_reg;
        scan_next      = scan_reg;
        used_next      = used_reg;
        full_next      = full_reg;
        nid_next       = nid_reg;
        res_ok_next    = res_ok_reg;
        res_idx_next   = res_idx_reg;
        res_id_next    = res_id_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_ok_next    = out_ok_reg;
        out_idx_next   = out_idx_reg;
        out_id_next    = out_id_reg;
        mem_ctl        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next      = req.op;
                    sidx_next    = req.slot_index;
                    key_next     = req.ident;
                    state_next   = ST_RESP;
                    res_ok_next  = 1'b0;
                    res_idx_next = '0;
                    res_id_next  = '0;
                    case (req.op)
                        OP_ADD:
                        begin
                            if (!full_reg)
                            begin
                                mem_ctl.wr_en = 1'b1;
                                res_ok_next   = 1'b1;
                                res_idx_next  = RES_IDX_W'(used_reg);
                                res_id_next   = nid_reg;
                                nid_next      = (nid_inc == '0) ? ID_WRAP : nid_inc;
                                used_next     = used_reg + 1'b1;
                                full_next     = !((used_ext + 1'b1) < eff_size);
                            end
                        end
                        OP_GET:
                        begin
                            if (!(req.slot_index == INDEX_NONE && req.ident == KEY_NONE)
                                && (sidx_ext < eff_size))
                            begin
                                scan_next  = CNT_W'(req.slot_index);
                                state_next = ST_READ;
                            end
                        end
                        OP_FIND:
                        begin
                            if (req.ident != KEY_NONE && used_reg != '0)
                            begin
                                scan_next  = '0;
                                state_next = ST_READ;
                            end
                        end
                        OP_CLEAR:
                        begin
                            used_next   = '0;
                            full_next   = 1'b0;
                            nid_next    = cfg.name_seed | ID_WRAP;
                            res_ok_next = 1'b1;
                        end
                        OP_ITER:
                        begin
                            if (sidx_ext < used_ext)
                            begin
                                scan_next  = CNT_W'(req.slot_index);
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            res_ok_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                mem_ctl.rd_en = 1'b1;
                state_next    = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (op_reg == OP_GET)
                begin
                    state_next = ST_RESP;
                    if (!((word == '0 && cfg.zero_id_invalid)
                          || (key_reg != '0 && !word_eq)))
                    begin
                        res_ok_next  = 1'b1;
                        res_idx_next = sidx_reg[RES_IDX_W-1:0];
                        res_id_next  = word;
                    end
                end
                else if (hit)
                begin
                    state_next   = ST_RESP;
                    res_ok_next  = 1'b1;
                    res_idx_next = RES_IDX_W'(scan_reg);
                    res_id_next  = word;
                end
                else if (scan_inc >= used_reg)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    scan_next  = scan_inc;
                    state_next = ST_READ;
                end
            end
            ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_idx_next   = res_idx_reg;
                    out_id_next    = res_id_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            full_reg      <= 1'b0;
            nid_reg       <= ID_WRAP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            full_reg      <= full_next;
            nid_reg       <= nid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        sidx_reg    <= sidx_next;
        key_reg     <= key_next;
        scan_reg    <= scan_next;
        res_ok_reg  <= res_ok_next;
        res_idx_reg <= res_idx_next;
        res_id_reg  <= res_id_next;
        out_ok_reg  <= out_ok_next;
        out_idx_reg <= out_idx_next;
        out_id_reg  <= out_id_next;
    end
endmodule

// File: src/salted_handle_slot_table_core.sv
// Top level of the salted handle slot table: config registers, sequencer, slot memory.
//
//   channel  dir  handshake          payload
//   req      in   valid/ready        op, slot_index, ident
//   rsp      out  valid/ready        ok, result_index, result_id
//   apb      in   psel/penable       paddr, pwdata, prdata
//
// Add, clear and failed checks go from idle straight to the response state; get
// passes once through the read and check states, find and iterate once per slot
// scanned (one memory read port, one shared compare). Reset needs no clearing
// pass: the fill count marks slots past the used region as empty. Response is held
// in an output register; a stalled response blocks only the next transaction's end.
module salted_handle_slot_table_core import shst_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    shst_req_if.sink           req,
    shst_rsp_if.source         rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);
    localparam int IDX_W = $clog2(CAPACITY);

    logic [TSIZE_W-1:0] table_size_reg;
    logic               zero_id_reg;
    logic [ID_W-1:0]    seed_reg;
    cfg_t               cfg;
    mem_ctl_t           mem_ctl;
    logic [IDX_W-1:0]   mem_waddr;
    logic [IDX_W-1:0]   mem_raddr;
    logic [ID_W-1:0]    mem_wdata;
    logic [ID_W-1:0]    mem_rdata;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= TSIZE_RST;
            zero_id_reg    <= 1'b1;
            seed_reg       <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[PADDR_W-1:2])
                REG_TABLE_SIZE: table_size_reg <= pwdata[TSIZE_W-1:0];
                REG_ZERO_ID:    zero_id_reg    <= pwdata[0];
                REG_NAME_SEED:  seed_reg       <= pwdata[ID_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[PADDR_W-1:2])
            REG_TABLE_SIZE: prdata = PDATA_W'(table_size_reg);
            REG_ZERO_ID:    prdata = PDATA_W'(zero_id_reg);
            REG_NAME_SEED:  prdata = PDATA_W'(seed_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.table_size      = table_size_reg;
    assign cfg.zero_id_invalid = zero_id_reg;
    assign cfg.name_seed       = seed_reg;

    shst_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg       (cfg),
        .mem_ctl   (mem_ctl),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    shst_mem #(
        .CAPACITY (CAPACITY)
    ) u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );
endmodule

// File: src/shst_chk.sv
// Port-level checker for the slot table, bound to the top level.
`include "salted_handle_slot_table_core_defines.svh"

module shst_chk import shst_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_ready,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input logic                 rsp_ok,
    input logic [RES_IDX_W-1:0] rsp_index,
    input logic [ID_W-1:0]      rsp_id
);
    `SHST_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
    `SHST_ASSERT_NXT(a_busy_after_accept, clk, rst_n, req_valid && req_ready, !req_ready, "ready right after accept")
    `SHST_ASSERT_IMP(a_fail_zero, clk, rst_n, rsp_valid && !rsp_ok, rsp_index == '0 && rsp_id == '0, "failed response not zeroed")
endmodule

bind salted_handle_slot_table_core shst_chk u_shst_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_ok    (rsp.ok),
    .rsp_index (rsp.result_index),
    .rsp_id    (rsp.result_id)
);
